// File: hdl/cpu_operand_access_unit_top_macros.svh
// Assertion helpers for the operand access unit controller (coau_ctrl).
// Each expects i_clk and i_rst_n in scope.
`ifndef CPU_OPERAND_ACCESS_UNIT_TOP_MACROS_SVH
`define CPU_OPERAND_ACCESS_UNIT_TOP_MACROS_SVH

// Same-cycle implication
`define COAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define COAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/coau_pkg.sv
package coau_pkg;

    localparam int unsigned NUM_REGS = 8;

    // 8-bit register codes
    localparam logic [2:0] REG_A = 3'd0;
    localparam logic [2:0] REG_B = 3'd1;
    localparam logic [2:0] REG_C = 3'd2;
    localparam logic [2:0] REG_D = 3'd3;
    localparam logic [2:0] REG_E = 3'd4;
    localparam logic [2:0] REG_F = 3'd5;
    localparam logic [2:0] REG_H = 3'd6;
    localparam logic [2:0] REG_L = 3'd7;

    // pair codes
    localparam logic [2:0] PAIR_AF = 3'd0;
    localparam logic [2:0] PAIR_BC = 3'd1;
    localparam logic [2:0] PAIR_DE = 3'd2;
    localparam logic [2:0] PAIR_HL = 3'd3;
    localparam logic [2:0] PAIR_SP = 3'd4;

    // indirect pointer codes
    localparam logic [2:0] IND_BC     = 3'd0;
    localparam logic [2:0] IND_DE     = 3'd1;
    localparam logic [2:0] IND_HL     = 3'd2;
    localparam logic [2:0] IND_HL_DEC = 3'd3;
    localparam logic [2:0] IND_HL_INC = 3'd4;

    // direct address codes
    localparam logic [2:0] DIR_FULL = 3'd0;
    localparam logic [2:0] DIR_HIGH = 3'd1;

    localparam logic [7:0] F_MASK       = 8'hF0;
    localparam logic [7:0] HIGH_PAGE_HI = 8'hFF;

    typedef enum logic [3:0] {
        ACT_REG8_RD = 4'd0,
        ACT_REG8_WR = 4'd1,
        ACT_PAIR_RD = 4'd2,
        ACT_PAIR_WR = 4'd3,
        ACT_IMM8    = 4'd4,
        ACT_IMM16   = 4'd5,
        ACT_IND_RD  = 4'd6,
        ACT_IND_WR  = 4'd7,
        ACT_DIR_RD  = 4'd8,
        ACT_DIR_WR  = 4'd9
    } t_action;

    typedef enum logic [2:0] {
        ST_S0 = 3'd0,
        ST_S1 = 3'd1,
        ST_S2 = 3'd2,
        ST_S3 = 3'd3,
        ST_S4 = 3'd4,
        ST_S5 = 3'd5
    } t_step;

    typedef enum logic [2:0] {
        AS_NONE,
        AS_PC,
        AS_PC_INC,
        AS_PTR,
        AS_TARGET
    } t_addr_sel;

    typedef enum logic [2:0] {
        VS_ZERO,
        VS_REG8,
        VS_PAIR,
        VS_RB,
        VS_IMM16
    } t_val_sel;

    typedef struct packed {
        logic      done;
        logic      bad;
        logic      rd;
        logic      wr;
        t_addr_sel addr_sel;
        t_val_sel  val_sel;
        logic      rf_wr8;
        logic      pair_wr;
        logic      pc_inc;
        logic      lo_ld;
        logic      hi_ld;
        logic      hi_page;
        logic      hl_dec;
        logic      hl_inc;
    } t_cmd;

endpackage

// File: hdl/coau_ctrl.sv
module coau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [3:0]     i_action,
    input  logic [2:0]     i_select,
    output coau_pkg::t_cmd o_cmd
);
    import coau_pkg::*;

`include "cpu_operand_access_unit_top_macros.svh"

    t_step r_step;
    t_step n_step;
    t_cmd  w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_S0;
        end else if (i_accept) begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w_cmd    = '0;
        w_cmd.addr_sel = AS_NONE;
        w_cmd.val_sel  = VS_ZERO;
        n_step   = r_step;
        case (t_action'(i_action))
            ACT_REG8_RD, ACT_REG8_WR: begin
                w_cmd.done = 1'b1;
                if (i_select == REG_F) begin
                    w_cmd.bad = 1'b1;
                end else if (t_action'(i_action) == ACT_REG8_RD) begin
                    w_cmd.val_sel = VS_REG8;
                end else begin
                    w_cmd.rf_wr8 = 1'b1;
                end
            end
            ACT_PAIR_RD, ACT_PAIR_WR: begin
                w_cmd.done = 1'b1;
                if (i_select > PAIR_SP) begin
                    w_cmd.bad = 1'b1;
                end else if (t_action'(i_action) == ACT_PAIR_RD) begin
                    w_cmd.val_sel = VS_PAIR;
                end else begin
                    w_cmd.pair_wr = 1'b1;
                end
            end
            ACT_IMM8: begin
                if (r_step == ST_S0) begin
                    w_cmd.addr_sel = AS_PC;
                    w_cmd.rd       = 1'b1;
                    n_step         = ST_S1;
                end else begin
                    w_cmd.val_sel = VS_RB;
                    w_cmd.pc_inc  = 1'b1;
                    w_cmd.done    = 1'b1;
                end
            end
            ACT_IMM16: begin
                case (r_step)
                    ST_S0: begin
                        w_cmd.addr_sel = AS_PC;
                        w_cmd.rd       = 1'b1;
                        n_step         = ST_S1;
                    end
                    ST_S1: begin
                        w_cmd.lo_ld    = 1'b1;
                        w_cmd.pc_inc   = 1'b1;
                        w_cmd.addr_sel = AS_PC_INC;
                        w_cmd.rd       = 1'b1;
                        n_step         = ST_S2;
                    end
                    default: begin
                        w_cmd.hi_ld   = 1'b1;
                        w_cmd.pc_inc  = 1'b1;
                        w_cmd.val_sel = VS_IMM16;
                        w_cmd.done    = 1'b1;
                    end
                endcase
            end
            ACT_IND_RD, ACT_IND_WR: begin
                if (i_select > IND_HL_INC) begin
                    w_cmd.done = 1'b1;
                    w_cmd.bad  = 1'b1;
                end else if (r_step == ST_S0) begin
                    if (t_action'(i_action) == ACT_IND_RD) begin
                        w_cmd.addr_sel = AS_PTR;
                        w_cmd.rd       = 1'b1;
                    end
                    n_step = ST_S1;
                end else begin
                    if (t_action'(i_action) == ACT_IND_RD) begin
                        w_cmd.val_sel = VS_RB;
                    end else begin
                        w_cmd.addr_sel = AS_PTR;
                        w_cmd.wr       = 1'b1;
                    end
                    w_cmd.hl_dec = (i_select == IND_HL_DEC);
                    w_cmd.hl_inc = (i_select == IND_HL_INC);
                    w_cmd.done   = 1'b1;
                end
            end
            ACT_DIR_RD, ACT_DIR_WR: begin
                if (i_select > DIR_HIGH) begin
                    w_cmd.done = 1'b1;
                    w_cmd.bad  = 1'b1;
                end else begin
                    case (r_step)
                        ST_S0: begin
                            w_cmd.addr_sel = AS_PC;
                            w_cmd.rd       = 1'b1;
                            n_step         = ST_S1;
                        end
                        ST_S1: begin
                            w_cmd.lo_ld  = 1'b1;
                            w_cmd.pc_inc = 1'b1;
                            if (i_select == DIR_HIGH) begin
                                w_cmd.hi_page = 1'b1;
                                n_step        = ST_S4;
                            end else begin
                                n_step = ST_S2;
                            end
                        end
                        ST_S2: begin
                            w_cmd.addr_sel = AS_PC;
                            w_cmd.rd       = 1'b1;
                            n_step         = ST_S3;
                        end
                        ST_S3: begin
                            w_cmd.hi_ld  = 1'b1;
                            w_cmd.pc_inc = 1'b1;
                            n_step       = ST_S4;
                        end
                        ST_S4: begin
                            if (t_action'(i_action) == ACT_DIR_RD) begin
                                w_cmd.addr_sel = AS_TARGET;
                                w_cmd.rd       = 1'b1;
                            end
                            n_step = ST_S5;
                        end
                        default: begin
                            if (t_action'(i_action) == ACT_DIR_RD) begin
                                w_cmd.val_sel = VS_RB;
                            end else begin
                                w_cmd.addr_sel = AS_TARGET;
                                w_cmd.wr       = 1'b1;
                            end
                            w_cmd.done = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                w_cmd.done = 1'b1;
                w_cmd.bad  = 1'b1;
            end
        endcase
        if (w_cmd.done) begin
            n_step = ST_S0;
        end
    end

    assign o_cmd = w_cmd;

    `COAU_ASSERT_NEXT(a_done_rewinds, i_accept && w_cmd.done, r_step == ST_S0, "step not rewound after done")
    `COAU_ASSERT_NOW(a_strobe_excl, 1'b1, !(w_cmd.rd && w_cmd.wr), "read and write strobe together")
    `COAU_ASSERT_NOW(a_bad_quiet, w_cmd.bad, w_cmd.done && !w_cmd.rd && !w_cmd.wr && !w_cmd.rf_wr8 && !w_cmd.pair_wr, "bad select with side effect")
    `COAU_ASSERT_NOW(a_addr_strobe, (w_cmd.addr_sel == AS_NONE), !w_cmd.rd && !w_cmd.wr, "strobe without address")

endmodule

// File: hdl/coau_dpath.sv
module coau_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_out_stall,
    input  coau_pkg::t_cmd i_cmd,
    input  logic [2:0]     i_select,
    input  logic [15:0]    i_write_data,
    input  logic [7:0]     i_bus_read_data,
    output logic           o_out_valid,
    output logic [15:0]    o_bus_address,
    output logic           o_bus_read_strobe,
    output logic           o_bus_write_strobe,
    output logic [7:0]     o_bus_write_byte,
    output logic           o_done_res,
    output logic [15:0]    o_operand_value,
    output logic           o_bad_select
);
    import coau_pkg::*;

    logic [7:0]  r_rf [NUM_REGS];
    logic [15:0] r_sp;
    logic [15:0] r_pc;
    logic [7:0]  r_lo;
    logic [7:0]  r_hi;
    logic        r_out_valid;
    logic [15:0] r_addr;
    logic        r_rd;
    logic        r_wr;
    logic [7:0]  r_wbyte;
    logic        r_done;
    logic [15:0] r_val;
    logic        r_bad;

    logic [15:0] w_ptr;
    logic [15:0] w_pair;
    logic [15:0] w_addr;
    logic [15:0] w_val;
    logic [15:0] w_hl;

    assign w_hl = {r_rf[REG_H], r_rf[REG_L]};

    always_comb begin
        case (i_select)
            IND_BC:  w_ptr = {r_rf[REG_B], r_rf[REG_C]};
            IND_DE:  w_ptr = {r_rf[REG_D], r_rf[REG_E]};
            default: w_ptr = w_hl;
        endcase
    end

    always_comb begin
        case (i_select)
            PAIR_AF: w_pair = {r_rf[REG_A], r_rf[REG_F]};
            PAIR_BC: w_pair = {r_rf[REG_B], r_rf[REG_C]};
            PAIR_DE: w_pair = {r_rf[REG_D], r_rf[REG_E]};
            PAIR_HL: w_pair = w_hl;
            default: w_pair = r_sp;
        endcase
    end

    always_comb begin
        case (i_cmd.addr_sel)
            AS_PC:     w_addr = r_pc;
            AS_PC_INC: w_addr = r_pc + 16'd1;
            AS_PTR:    w_addr = w_ptr;
            AS_TARGET: w_addr = {r_hi, r_lo};
            default:   w_addr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.val_sel)
            VS_REG8:  w_val = {8'd0, r_rf[i_select]};
            VS_PAIR:  w_val = w_pair;
            VS_RB:    w_val = {8'd0, i_bus_read_data};
            VS_IMM16: w_val = {i_bus_read_data, r_lo};
            default:  w_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_rf[i] <= '0;
            end
            r_sp        <= '0;
            r_pc        <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                if (i_cmd.rf_wr8) begin
                    r_rf[i_select] <= i_write_data[7:0];
                end
                if (i_cmd.pair_wr) begin
                    case (i_select)
                        PAIR_AF: begin
                            r_rf[REG_A] <= i_write_data[15:8];
                            r_rf[REG_F] <= i_write_data[7:0] & F_MASK;
                        end
                        PAIR_BC: {r_rf[REG_B], r_rf[REG_C]} <= i_write_data;
                        PAIR_DE: {r_rf[REG_D], r_rf[REG_E]} <= i_write_data;
                        PAIR_HL: {r_rf[REG_H], r_rf[REG_L]} <= i_write_data;
                        default: r_sp <= i_write_data;
                    endcase
                end
                if (i_cmd.hl_dec) begin
                    {r_rf[REG_H], r_rf[REG_L]} <= w_hl - 16'd1;
                end
                if (i_cmd.hl_inc) begin
                    {r_rf[REG_H], r_rf[REG_L]} <= w_hl + 16'd1;
                end
                if (i_cmd.pc_inc) begin
                    r_pc <= r_pc + 16'd1;
                end
                if (i_cmd.lo_ld) begin
                    r_lo <= i_bus_read_data;
                end
                if (i_cmd.hi_ld) begin
                    r_hi <= i_bus_read_data;
                end
                if (i_cmd.hi_page) begin
                    r_hi <= HIGH_PAGE_HI;
                end
            end
            if (i_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_addr  <= w_addr;
            r_rd    <= i_cmd.rd;
            r_wr    <= i_cmd.wr;
            r_wbyte <= i_cmd.wr ? i_write_data[7:0] : 8'd0;
            r_done  <= i_cmd.done;
            r_val   <= w_val;
            r_bad   <= i_cmd.bad;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_bus_address      = r_addr;
    assign o_bus_read_strobe  = r_rd;
    assign o_bus_write_strobe = r_wr;
    assign o_bus_write_byte   = r_wbyte;
    assign o_done_res         = r_done;
    assign o_operand_value    = r_val;
    assign o_bad_select       = r_bad;

endmodule

// File: hdl/cpu_operand_access_unit_top.sv
// Operand access unit: holds A..L, SP, PC and a step counter, and turns each
// accepted input word (one machine tick) into one result word carrying the bus
// request and done flag. A new word is accepted each cycle while the result
// register is free or being drained, and the registered result appears on the
// output in the cycle after acceptance. Register accesses finish in one tick;
// imm8 and indirect accesses take 2 ticks, imm16 3, direct high page 4 and direct
// full address 6, sequenced by the step counter in the controller. The byte for a
// read strobe is expected on the bus read data field of the following word.
module cpu_operand_access_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_action,
    input  logic [2:0]  i_select,
    input  logic [15:0] i_write_data,
    input  logic [7:0]  i_bus_read_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_bus_address,
    output logic        o_bus_read_strobe,
    output logic        o_bus_write_strobe,
    output logic [7:0]  o_bus_write_byte,
    output logic        o_done_res,
    output logic [15:0] o_operand_value,
    output logic        o_bad_select
);
    import coau_pkg::*;

    t_cmd w_cmd;
    logic w_accept;

    assign o_in_stall = o_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    coau_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_action (i_action),
        .i_select (i_select),
        .o_cmd    (w_cmd)
    );

    coau_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (w_accept),
        .i_out_stall        (i_out_stall),
        .i_cmd              (w_cmd),
        .i_select           (i_select),
        .i_write_data       (i_write_data),
        .i_bus_read_data    (i_bus_read_data),
        .o_out_valid        (o_out_valid),
        .o_bus_address      (o_bus_address),
        .o_bus_read_strobe  (o_bus_read_strobe),
        .o_bus_write_strobe (o_bus_write_strobe),
        .o_bus_write_byte   (o_bus_write_byte),
        .o_done_res         (o_done_res),
        .o_operand_value    (o_operand_value),
        .o_bad_select       (o_bad_select)
    );

endmodule

// File: dv/tb_cpu_operand_access_unit_top.sv
`timescale 1ns / 1ps

module tb_cpu_operand_access_unit_top;
    import coau_pkg::*;

    localparam int          STALL_LIMIT   = 2000;
    localparam int          PHASE_WORDS   = 530;
    localparam logic [3:0]  ACT_UNDEFINED = 4'hF;

    typedef struct packed {
        logic [15:0] addr;
        logic        rd;
        logic        wr;
        logic [7:0]  wbyte;
        logic        done;
        logic [15:0] val;
        logic        bad;
    } t_tick_result;

    logic        i_clk;
    logic        i_rst_n            = 1'b0;
    logic        i_in_valid         = 1'b0;
    logic        o_in_stall;
    logic [3:0]  i_action           = '0;
    logic [2:0]  i_select           = '0;
    logic [15:0] i_write_data       = '0;
    logic [7:0]  i_bus_read_data    = '0;
    logic        o_out_valid;
    logic        i_out_stall        = 1'b0;
    logic [15:0] o_bus_address;
    logic        o_bus_read_strobe;
    logic        o_bus_write_strobe;
    logic [7:0]  o_bus_write_byte;
    logic        o_done_res;
    logic [15:0] o_operand_value;
    logic        o_bad_select;

    // machine state mirrored from the block
    logic [7:0]  gpr [NUM_REGS];
    logic [15:0] sp_reg;
    logic [15:0] pc_reg;
    t_step       step_cnt;
    logic [7:0]  lo_latch;
    logic [7:0]  hi_latch;

    t_tick_result tick_results[$];
    t_tick_result got_word;
    t_tick_result want_word;
    logic         last_done;

    int in_idle_pct  = 7;
    int out_idle_pct = 50;
    int words_sent   = 0;
    int words_seen   = 0;
    int n_done       = 0;
    int n_bad        = 0;
    int n_reads      = 0;
    int n_writes     = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;

    cpu_operand_access_unit_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_select           (i_select),
        .i_write_data       (i_write_data),
        .i_bus_read_data    (i_bus_read_data),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_bus_address      (o_bus_address),
        .o_bus_read_strobe  (o_bus_read_strobe),
        .o_bus_write_strobe (o_bus_write_strobe),
        .o_bus_write_byte   (o_bus_write_byte),
        .o_done_res         (o_done_res),
        .o_operand_value    (o_operand_value),
        .o_bad_select       (o_bad_select)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // One machine tick: bus request, completion and value; updates mirrored state.
    function automatic t_tick_result access_tick(input logic [3:0] act, input logic [2:0] sel,
                                                 input logic [15:0] wd, input logic [7:0] rb);
        t_tick_result r;
        logic [15:0]  ptr;
        logic [15:0]  target;
        t_step        s;
        r = '0;
        s = step_cnt;
        case (act)
            ACT_REG8_RD, ACT_REG8_WR: begin
                r.done = 1'b1;
                if (sel == REG_F) r.bad = 1'b1;
                else if (act == ACT_REG8_RD) r.val = {8'h00, gpr[sel]};
                else gpr[sel] = wd[7:0];
            end
            ACT_PAIR_RD, ACT_PAIR_WR: begin
                r.done = 1'b1;
                if (sel > PAIR_SP) begin
                    r.bad = 1'b1;
                end else if (act == ACT_PAIR_RD) begin
                    case (sel)
                        PAIR_AF: r.val = {gpr[REG_A], gpr[REG_F]};
                        PAIR_BC: r.val = {gpr[REG_B], gpr[REG_C]};
                        PAIR_DE: r.val = {gpr[REG_D], gpr[REG_E]};
                        PAIR_HL: r.val = {gpr[REG_H], gpr[REG_L]};
                        default: r.val = sp_reg;
                    endcase
                end else begin
                    case (sel)
                        PAIR_AF: {gpr[REG_A], gpr[REG_F]} = {wd[15:8], wd[7:0] & F_MASK};
                        PAIR_BC: {gpr[REG_B], gpr[REG_C]} = wd;
                        PAIR_DE: {gpr[REG_D], gpr[REG_E]} = wd;
                        PAIR_HL: {gpr[REG_H], gpr[REG_L]} = wd;
                        default: sp_reg = wd;
                    endcase
                end
            end
            ACT_IMM8: begin
                if (s == ST_S0) begin
                    r.addr   = pc_reg;
                    r.rd     = 1'b1;
                    step_cnt = ST_S1;
                end else begin
                    r.val  = {8'h00, rb};
                    pc_reg = pc_reg + 16'd1;
                    r.done = 1'b1;
                end
            end
            ACT_IMM16: begin
                if (s == ST_S0) begin
                    r.addr   = pc_reg;
                    r.rd     = 1'b1;
                    step_cnt = ST_S1;
                end else if (s == ST_S1) begin
                    lo_latch = rb;
                    pc_reg   = pc_reg + 16'd1;
                    r.addr   = pc_reg;
                    r.rd     = 1'b1;
                    step_cnt = ST_S2;
                end else begin
                    hi_latch = rb;
                    pc_reg   = pc_reg + 16'd1;
                    r.val    = {hi_latch, lo_latch};
                    r.done   = 1'b1;
                end
            end
            ACT_IND_RD, ACT_IND_WR: begin
                if (sel > IND_HL_INC) begin
                    r.done = 1'b1;
                    r.bad  = 1'b1;
                end else begin
                    case (sel)
                        IND_BC:  ptr = {gpr[REG_B], gpr[REG_C]};
                        IND_DE:  ptr = {gpr[REG_D], gpr[REG_E]};
                        default: ptr = {gpr[REG_H], gpr[REG_L]};
                    endcase
                    if (s == ST_S0) begin
                        if (act == ACT_IND_RD) begin
                            r.addr = ptr;
                            r.rd   = 1'b1;
                        end
                        step_cnt = ST_S1;
                    end else begin
                        if (act == ACT_IND_RD) begin
                            r.val = {8'h00, rb};
                        end else begin
                            r.addr  = ptr;
                            r.wr    = 1'b1;
                            r.wbyte = wd[7:0];
                        end
                        if (sel == IND_HL_DEC) {gpr[REG_H], gpr[REG_L]} = ptr - 16'd1;
                        else if (sel == IND_HL_INC) {gpr[REG_H], gpr[REG_L]} = ptr + 16'd1;
                        r.done = 1'b1;
                    end
                end
            end
            ACT_DIR_RD, ACT_DIR_WR: begin
                if (sel > DIR_HIGH) begin
                    r.done = 1'b1;
                    r.bad  = 1'b1;
                end else begin
                    target = {hi_latch, lo_latch};
                    case (s)
                        ST_S0, ST_S2: begin
                            r.addr   = pc_reg;
                            r.rd     = 1'b1;
                            step_cnt = (s == ST_S0) ? ST_S1 : ST_S3;
                        end
                        ST_S1: begin
                            lo_latch = rb;
                            pc_reg   = pc_reg + 16'd1;
                            if (sel == DIR_HIGH) begin
                                hi_latch = HIGH_PAGE_HI;
                                step_cnt = ST_S4;
                            end else begin
                                step_cnt = ST_S2;
                            end
                        end
                        ST_S3: begin
                            hi_latch = rb;
                            pc_reg   = pc_reg + 16'd1;
                            step_cnt = ST_S4;
                        end
                        ST_S4: begin
                            if (act == ACT_DIR_RD) begin
                                r.addr = target;
                                r.rd   = 1'b1;
                            end
                            step_cnt = ST_S5;
                        end
                        default: begin
                            if (act == ACT_DIR_RD) begin
                                r.val = {8'h00, rb};
                            end else begin
                                r.addr  = target;
                                r.wr    = 1'b1;
                                r.wbyte = wd[7:0];
                            end
                            r.done = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                r.done = 1'b1;
                r.bad  = 1'b1;
            end
        endcase
        if (r.done) step_cnt = ST_S0;
        return r;
    endfunction

    task automatic send_word(input logic [3:0] act, input logic [2:0] sel,
                             input logic [15:0] wd, input logic [7:0] rb);
        t_tick_result r;
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_select        <= sel;
        i_write_data    <= wd;
        i_bus_read_data <= rb;
        do @(posedge i_clk); while (o_in_stall);
        r = access_tick(act, sel, wd, rb);
        tick_results.push_back(r);
        last_done = r.done;
        words_sent++;
    endtask

    // Ticks of one access with random data until it completes; broken_pct of the
    // later ticks switch to an arbitrary word instead.
    task automatic run_access(input logic [3:0] act, input logic [2:0] sel, input int broken_pct);
        int n = 0;
        do begin
            if (n > 0 && $urandom_range(99) < broken_pct)
                send_word(4'($urandom_range(15)), 3'($urandom), 16'($urandom), 8'($urandom));
            else
                send_word(act, sel, 16'($urandom), 8'($urandom));
            n++;
        end while (!last_done && n < 8);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tick_results.size() != 0);
    endtask

    task automatic test_register_file();
        send_word(ACT_REG8_RD, REG_A, 16'h0000, 8'h00);
        send_word(ACT_REG8_WR, REG_B, 16'hFFFF, 8'hFF);
        send_word(ACT_REG8_RD, REG_B, 16'h0000, 8'h00);
        send_word(ACT_REG8_WR, REG_F, 16'h00FF, 8'h00);  // F is not byte-addressable
        send_word(ACT_PAIR_WR, PAIR_AF, 16'hFFFF, 8'h00); // F low nibble forced to zero
        send_word(ACT_PAIR_RD, PAIR_AF, 16'h0000, 8'h00);
        send_word(ACT_PAIR_RD, 3'd7, 16'h0000, 8'h00);
    endtask

    task automatic test_immediates();
        send_word(ACT_IMM8, 3'd0, 16'h0000, 8'h00);
        send_word(ACT_IMM8, 3'd7, 16'h0000, 8'hFF);
        send_word(ACT_IMM16, 3'd0, 16'h0000, 8'hAA);
        send_word(ACT_IMM16, 3'd0, 16'h0000, 8'h00);
        send_word(ACT_IMM16, 3'd0, 16'h0000, 8'hFF);
    endtask

    task automatic test_indirect();
        send_word(ACT_PAIR_WR, PAIR_HL, 16'h0000, 8'h00);
        run_access(ACT_IND_RD, IND_HL_DEC, 0);   // HL wraps down to FFFF
        run_access(ACT_IND_WR, IND_HL_INC, 0);   // and back up to 0000
        send_word(ACT_IND_RD, 3'd5, 16'h0000, 8'h00);
    endtask

    task automatic test_direct();
        run_access(ACT_DIR_RD, DIR_FULL, 0);
        run_access(ACT_DIR_WR, DIR_HIGH, 0);
        send_word(ACT_DIR_WR, 3'd2, 16'h0000, 8'h00);
    endtask

    task automatic test_undefined_action();
        send_word(ACT_UNDEFINED, 3'd0, 16'hFFFF, 8'hFF);
    endtask

    task automatic test_mid_sequence_switch();
        send_word(ACT_IMM16, 3'd0, 16'h0000, 8'h12);
        send_word(ACT_IMM8, 3'd0, 16'h0000, 8'h34);   // imm8 picked up at step 1
        send_word(ACT_DIR_WR, DIR_HIGH, 16'h0000, 8'h00);
        send_word(ACT_DIR_WR, DIR_HIGH, 16'h0000, 8'h80);
        send_word(ACT_IMM16, 3'd0, 16'h0000, 8'h55); // step past imm16's last step
    endtask

    task automatic test_random_traffic(input int in_pct, input int out_pct, input int n_words);
        int          stop_at;
        int          drain_at;
        logic [3:0]  act;
        logic [2:0]  sel;
        int          sel_max;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        stop_at      = words_sent + n_words;
        drain_at     = words_sent + n_words / 2;
        while (words_sent < stop_at) begin
            if (words_sent >= drain_at) begin
                drain_results();
                drain_at = stop_at;
            end
            if ($urandom_range(99) < 10) begin
                send_word(4'($urandom_range(15)), 3'($urandom), 16'($urandom), 8'($urandom));
            end else begin
                act = 4'($urandom_range(ACT_DIR_WR));
                case (act)
                    ACT_PAIR_RD, ACT_PAIR_WR, ACT_IND_RD, ACT_IND_WR: sel_max = 4;
                    ACT_DIR_RD, ACT_DIR_WR:                             sel_max = 1;
                    default:                                            sel_max = 7;
                endcase
                if ($urandom_range(99) < 90) sel = 3'($urandom_range(sel_max));
                else sel = 3'($urandom);
                run_access(act, sel, 5);
            end
        end
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_word.addr  = o_bus_address;
            got_word.rd    = o_bus_read_strobe;
            got_word.wr    = o_bus_write_strobe;
            got_word.wbyte = o_bus_write_byte;
            got_word.done  = o_done_res;
            got_word.val   = o_operand_value;
            got_word.bad   = o_bad_select;
            words_seen++;
            n_done   += got_word.done;
            n_bad    += got_word.bad;
            n_reads  += got_word.rd;
            n_writes += got_word.wr;
            if (tick_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with nothing pending: addr=%h done=%b", $realtime,
                             got_word.addr, got_word.done);
            end else begin
                want_word = tick_results.pop_front();
                if (got_word !== want_word) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: word %0d mismatch", $realtime, words_seen);
                        $display("  exp addr=%h rd=%b wr=%b wbyte=%h done=%b val=%h bad=%b",
                                 want_word.addr, want_word.rd, want_word.wr, want_word.wbyte,
                                 want_word.done, want_word.val, want_word.bad);
                        $display("  got addr=%h rd=%b wr=%b wbyte=%h done=%b val=%h bad=%b",
                                 got_word.addr, got_word.rd, got_word.wr, got_word.wbyte,
                                 got_word.done, got_word.val, got_word.bad);
                    end
                end
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_REGS; i++) gpr[i] = 8'h00;
        sp_reg    = '0;
        pc_reg    = '0;
        step_cnt  = ST_S0;
        lo_latch  = '0;
        hi_latch  = '0;
        last_done = 1'b1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_file();
        test_immediates();
        test_indirect();
        test_direct();
        test_undefined_action();
        test_mid_sequence_switch();

        test_random_traffic(7, 50, PHASE_WORDS);
        test_random_traffic(50, 7, PHASE_WORDS);
        test_random_traffic(0, 0, PHASE_WORDS);

        drain_results();
        repeat (8) @(posedge i_clk);
        mismatches += tick_results.size();

        $display("Covered %0d input words and %0d result words across three stall mixes",
                 words_sent, words_seen);
        $display("  %0d accesses completed, %0d bad selects, %0d bus reads, %0d bus writes",
                 n_done, n_bad, n_reads, n_writes);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: cpu_operand_access_unit_top.f
+incdir+hdl
hdl/coau_pkg.sv
hdl/coau_ctrl.sv
hdl/coau_dpath.sv
hdl/cpu_operand_access_unit_top.sv
dv/tb_cpu_operand_access_unit_top.sv
